// ===== rtl/multibulk_request_parser_macros.svh =====
// Assertion macros used by the checker file
`ifndef MULTIBULK_REQUEST_PARSER_MACROS_SVH
`define MULTIBULK_REQUEST_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define MRP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define MRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/mrp_pkg.sv =====
package mrp_pkg;

  // Field widths
  localparam int BYTE_W    = 8;
  localparam int ARG_NUM_W = 10;
  localparam int ERR_W     = 2;
  localparam int CNT_W     = 11;
  localparam int LEN_W     = 30;

  // Default limits
  localparam int MAX_DIGITS_DEF = 10;
  localparam int MAX_ARGS_DEF   = 1024;

  // Register reset values
  localparam logic [CNT_W-1:0] MAX_ARG_COUNT_RST   = 11'd1024;
  localparam logic [LEN_W-1:0] MAX_BULK_LENGTH_RST = 30'd536870912;

  // Configuration register indexes
  localparam logic REG_MAX_ARG_COUNT   = 1'b0;
  localparam logic REG_MAX_BULK_LENGTH = 1'b1;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_LEAD  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_LEN   = 2'd2;
  localparam logic [ERR_W-1:0] ERR_COUNT = 2'd3;

  // Framing characters
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

  // Trailing bytes after each argument
  localparam logic [LEN_W-1:0] TRAIL_LEN = 30'd2;

  // Parser phases
  typedef enum logic [6:0] {
    PH_HEADER = 7'b0000001,
    PH_RESYNC = 7'b0000010,
    PH_COUNT  = 7'b0000100,
    PH_LEAD   = 7'b0001000,
    PH_LENGTH = 7'b0010000,
    PH_DATA   = 7'b0100000,
    PH_TRAIL  = 7'b1000000
  } phase_t;

endpackage

// ===== rtl/multibulk_request_parser.sv =====
// Channel  Direction  Handshake           Beat
// in       sink       in_valid/in_stall   in_byte
// out      source     out_valid/out_stall data_byte, payload_valid, arg_number,
//                                         arg_end, command_end, error_code
// cfg      sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
// One byte per cycle sustained unless out_stall holds a full result register:
// a byte sits in the input register, then one parse step writes the state and
// the result register, which drives the outputs.
// rst (synchronous) returns the parser to waiting for a command header.
// in_stall rises only while a byte waits behind a stalled, full result register.
module multibulk_request_parser #(
  parameter int MAX_DIGITS = mrp_pkg::MAX_DIGITS_DEF,
  parameter int MAX_ARGS   = mrp_pkg::MAX_ARGS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mrp_pkg::BYTE_W-1:0]     in_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mrp_pkg::BYTE_W-1:0]     data_byte,
  output logic                           payload_valid,
  output logic [mrp_pkg::ARG_NUM_W-1:0]  arg_number,
  output logic                           arg_end,
  output logic                           command_end,
  output logic [mrp_pkg::ERR_W-1:0]      error_code,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [mrp_pkg::LEN_W-1:0]      cfg_data
);
  import mrp_pkg::*;

  localparam int DIG_W = $clog2(MAX_DIGITS + 1);
  localparam logic [DIG_W-1:0] DigMax = DIG_W'(MAX_DIGITS);
  localparam logic [16:0] MaxArgsW = 17'(MAX_ARGS);
  localparam int NUM_W = LEN_W + 4;

  // Configuration registers
  logic [CNT_W-1:0] max_arg_count;
  logic [LEN_W-1:0] max_bulk_length;

  // Input register
  logic              in_full;
  logic [BYTE_W-1:0] in_reg;

  // Parse state
  phase_t            phase, phase_next;
  logic [LEN_W-1:0]  number_value, number_value_next;
  logic [DIG_W-1:0]  digit_count, digit_count_next;
  logic              number_frozen, number_frozen_next;
  logic [CNT_W-1:0]  args_remaining, args_remaining_next;
  logic [ARG_NUM_W-1:0] arg_position, arg_position_next;
  logic [LEN_W-1:0]  bytes_remaining, bytes_remaining_next;

  // Step results
  logic                 res_valid;
  logic [BYTE_W-1:0]    res_byte;
  logic                 res_pv;
  logic [ARG_NUM_W-1:0] res_argn;
  logic                 res_aend;
  logic                 res_cend;
  logic [ERR_W-1:0]     res_err;

  logic              step;
  logic [CNT_W-1:0]  count_limit;
  logic [LEN_W-1:0]  num_limit;
  logic              is_digit;
  logic [NUM_W-1:0]  num_acc;
  logic              num_fail;
  logic [LEN_W-1:0]  bytes_dec;

  // Parse step runs when the result register is free or draining
  assign step      = in_full && !(out_valid && out_stall);
  assign in_stall  = in_full && !step;
  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_arg_count   <= MAX_ARG_COUNT_RST;
      max_bulk_length <= MAX_BULK_LENGTH_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MAX_ARG_COUNT:   max_arg_count   <= cfg_data[CNT_W-1:0];
        REG_MAX_BULK_LENGTH: max_bulk_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg <= in_byte;
    end
  end

  // Limit in force and decimal accumulation
  assign count_limit = ({6'd0, max_arg_count} < MaxArgsW) ? max_arg_count : CNT_W'(MAX_ARGS);
  assign num_limit   = (phase == PH_COUNT) ? {{(LEN_W-CNT_W){1'b0}}, count_limit}
                                           : max_bulk_length;
  assign is_digit    = (in_reg >= CH_ZERO) && (in_reg <= CH_NINE);
  assign num_acc     = ({4'd0, number_value} << 3) + ({4'd0, number_value} << 1)
                     + {{(NUM_W-4){1'b0}}, in_reg[3:0]};
  assign num_fail    = is_digit && !number_frozen &&
                       ((digit_count >= DigMax) || (num_acc > {4'd0, num_limit}));
  assign bytes_dec   = bytes_remaining - LEN_W'(1);

  // Parse step
  always_comb begin
    phase_next           = phase;
    number_value_next    = number_value;
    digit_count_next     = digit_count;
    number_frozen_next   = number_frozen;
    args_remaining_next  = args_remaining;
    arg_position_next    = arg_position;
    bytes_remaining_next = bytes_remaining;
    res_valid = 1'b0;
    res_byte  = '0;
    res_pv    = 1'b0;
    res_argn  = '0;
    res_aend  = 1'b0;
    res_cend  = 1'b0;
    res_err   = ERR_NONE;

    unique case (phase)
      PH_HEADER, PH_RESYNC: begin
        if (in_reg == CH_STAR) begin
          phase_next         = PH_COUNT;
          number_value_next  = '0;
          digit_count_next   = '0;
          number_frozen_next = 1'b0;
        end else if (phase == PH_HEADER) begin
          phase_next = PH_RESYNC;
          res_valid  = 1'b1;
          res_err    = ERR_LEAD;
        end
      end
      PH_COUNT, PH_LENGTH: begin
        if (in_reg == CH_LF) begin
          number_value_next  = '0;
          digit_count_next   = '0;
          number_frozen_next = 1'b0;
          if (phase == PH_COUNT) begin
            if (number_value == '0) begin
              phase_next = PH_HEADER;
            end else begin
              args_remaining_next = number_value[CNT_W-1:0];
              arg_position_next   = '0;
              phase_next          = PH_LEAD;
            end
          end else begin
            if (number_value == '0) begin
              bytes_remaining_next = TRAIL_LEN;
              phase_next           = PH_TRAIL;
            end else begin
              bytes_remaining_next = number_value;
              phase_next           = PH_DATA;
            end
          end
        end else if (num_fail) begin
          phase_next           = PH_RESYNC;
          args_remaining_next  = '0;
          arg_position_next    = '0;
          bytes_remaining_next = '0;
          number_value_next    = '0;
          digit_count_next     = '0;
          number_frozen_next   = 1'b0;
          res_valid            = 1'b1;
          res_err              = (phase == PH_COUNT) ? ERR_COUNT : ERR_LEN;
        end else if (in_reg == CH_CR) begin
          // carriage returns leave the number untouched
        end else if (!is_digit) begin
          number_frozen_next = 1'b1;
        end else if (!number_frozen) begin
          number_value_next = num_acc[LEN_W-1:0];
          digit_count_next  = digit_count + DIG_W'(1);
        end
      end
      PH_LEAD: begin
        number_value_next  = '0;
        digit_count_next   = '0;
        number_frozen_next = 1'b0;
        if (in_reg == CH_DOLLAR) begin
          phase_next = PH_LENGTH;
        end else begin
          phase_next           = PH_RESYNC;
          args_remaining_next  = '0;
          arg_position_next    = '0;
          bytes_remaining_next = '0;
          res_valid            = 1'b1;
          res_err              = ERR_LEAD;
        end
      end
      PH_DATA: begin
        res_valid = 1'b1;
        res_byte  = in_reg;
        res_pv    = 1'b1;
        res_argn  = arg_position;
        if (bytes_dec == '0) begin
          bytes_remaining_next = TRAIL_LEN;
          phase_next           = PH_TRAIL;
        end else begin
          bytes_remaining_next = bytes_dec;
        end
      end
      PH_TRAIL: begin
        bytes_remaining_next = bytes_dec;
        if (bytes_dec == '0) begin
          res_valid = 1'b1;
          res_argn  = arg_position;
          res_aend  = 1'b1;
          if (args_remaining <= CNT_W'(1)) begin
            res_cend            = 1'b1;
            args_remaining_next = '0;
            arg_position_next   = '0;
            phase_next          = PH_HEADER;
          end else begin
            args_remaining_next = args_remaining - CNT_W'(1);
            arg_position_next   = arg_position + ARG_NUM_W'(1);
            phase_next          = PH_LEAD;
          end
        end
      end
      default: phase_next = PH_RESYNC;
    endcase
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      number_value    <= '0;
      digit_count     <= '0;
      number_frozen   <= 1'b0;
      args_remaining  <= '0;
      arg_position    <= '0;
      bytes_remaining <= '0;
    end else if (step) begin
      phase           <= phase_next;
      number_value    <= number_value_next;
      digit_count     <= digit_count_next;
      number_frozen   <= number_frozen_next;
      args_remaining  <= args_remaining_next;
      arg_position    <= arg_position_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      data_byte     <= res_byte;
      payload_valid <= res_pv;
      arg_number    <= res_argn;
      arg_end       <= res_aend;
      command_end   <= res_cend;
      error_code    <= res_err;
    end
  end

endmodule

// ===== rtl/multibulk_request_parser_checker.sv =====
`include "multibulk_request_parser_macros.svh"

module multibulk_request_parser_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [mrp_pkg::BYTE_W-1:0]     data_byte,
  input logic                           payload_valid,
  input logic [mrp_pkg::ARG_NUM_W-1:0]  arg_number,
  input logic                           arg_end,
  input logic                           command_end,
  input logic [mrp_pkg::ERR_W-1:0]      error_code
);
  import mrp_pkg::*;

  // Error beats carry nothing else
  `MRP_ASSERT_NOW(a_err_clean, clk, rst, out_valid && (error_code != ERR_NONE), !payload_valid && !arg_end && !command_end && (arg_number == '0) && (data_byte == '0))

  // Command end only on an argument marker
  `MRP_ASSERT_NOW(a_cmd_on_marker, clk, rst, out_valid && command_end, arg_end && !payload_valid)

  // Non-payload beats have a zero data byte
  `MRP_ASSERT_NOW(a_data_zero, clk, rst, out_valid && !payload_valid, data_byte == '0)

  // A stalled beat holds
  `MRP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(data_byte) && $stable(arg_number) && $stable(error_code))

endmodule

bind multibulk_request_parser multibulk_request_parser_checker u_checker (.*);

// ===== bench/tb_multibulk_request_parser.sv =====
`timescale 1ns / 100ps

module tb_multibulk_request_parser;
  import mrp_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int STALL_LIMIT   = 5000;  // cycles without any beat before giving up
  localparam int PHASE_BYTES   = 145;
  localparam int NUM_PHASES    = 6;
  localparam int REPORT_MAX    = 10;

  // One output beat, laid out in port order
  typedef struct packed {
    logic [BYTE_W-1:0]    data_byte;
    logic                 payload_valid;
    logic [ARG_NUM_W-1:0] arg_number;
    logic                 arg_end;
    logic                 command_end;
    logic [ERR_W-1:0]     error_code;
  } frame_beat_t;

  // Directed row: a run of stream bytes, the last one optionally with a typed error
  typedef struct {
    string            text;
    bit               typed;
    logic [ERR_W-1:0] err;
  } stim_row_t;

  typedef struct {
    int unsigned arg_cap;
    int unsigned len_cap;
    int unsigned send_pct;
    int unsigned recv_pct;
  } limit_plan_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [BYTE_W-1:0]    in_byte = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [BYTE_W-1:0]    data_byte;
  logic                 payload_valid;
  logic [ARG_NUM_W-1:0] arg_number;
  logic                 arg_end;
  logic                 command_end;
  logic [ERR_W-1:0]     error_code;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_index = REG_MAX_ARG_COUNT;
  logic [LEN_W-1:0]     cfg_data = '0;

  multibulk_request_parser i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .data_byte    (data_byte),
    .payload_valid(payload_valid),
    .arg_number   (arg_number),
    .arg_end      (arg_end),
    .command_end  (command_end),
    .error_code   (error_code),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Directed stream: wrong lead after reset, zero count, CR in a count, empty
  // argument, top data byte, frozen count, count and length just over limit
  stim_row_t directed_rows [7] = '{
    '{"x",              1'b1, ERR_LEAD},
    '{"*0\n",           1'b0, ERR_NONE},
    '{"*2\r\n$0\n\r\n", 1'b0, ERR_NONE},
    '{"$1\n\377\r\n",   1'b0, ERR_NONE},
    '{"*1x5\n#",        1'b1, ERR_LEAD},
    '{"*1025",          1'b1, ERR_COUNT},
    '{"*1\n$536870913", 1'b1, ERR_LEN}
  };

  limit_plan_t limit_plans [NUM_PHASES] = '{
    '{4,    12,         20, 48},
    '{1,    0,          20, 48},
    '{1024, 536870911,  48, 20},
    '{7,    30,         48, 20},
    '{1024, 536870912,  0,  0},
    '{2,    6,          0,  0}
  };

  // Parser mirror: state and register copies
  phase_t            phase_q       = PH_HEADER;
  logic [LEN_W-1:0]  num_val       = '0;
  logic [3:0]        num_digits    = '0;
  logic              num_frozen    = 1'b0;
  logic [CNT_W-1:0]  args_left     = '0;
  logic [ARG_NUM_W-1:0] arg_idx    = '0;
  logic [LEN_W-1:0]  bytes_left    = '0;
  logic [CNT_W-1:0]  arg_limit_reg = MAX_ARG_COUNT_RST;
  logic [LEN_W-1:0]  len_limit_reg = MAX_BULK_LENGTH_RST;

  frame_beat_t       expected_beats [$];
  logic [BYTE_W-1:0] pending_bytes [$];

  int unsigned send_idle_pct   = 0;
  int unsigned recv_idle_pct   = 0;
  int unsigned bytes_fed       = 0;
  int unsigned beats_checked   = 0;
  int unsigned error_beats     = 0;
  int unsigned commands_closed = 0;
  int unsigned mismatches      = 0;
  int unsigned quiet_cycles    = 0;

  function automatic void clear_number();
    num_val    = '0;
    num_digits = '0;
    num_frozen = 1'b0;
  endfunction

  // Feeds one character to the number being read; 1 when it breaks the number
  function automatic bit number_breaks(input logic [BYTE_W-1:0] b, input logic [31:0] limit);
    logic [63:0] v;
    if (b == CH_CR)
      return 1'b0;
    if (b < CH_ZERO || b > CH_NINE) begin
      num_frozen = 1'b1;
      return 1'b0;
    end
    if (num_frozen)
      return 1'b0;
    if (num_digits >= MAX_DIGITS_DEF)
      return 1'b1;
    v = {34'd0, num_val} * 64'd10 + {56'd0, b - CH_ZERO};
    if (v > {32'd0, limit})
      return 1'b1;
    num_val    = v[LEN_W-1:0];
    num_digits = num_digits + 4'd1;
    return 1'b0;
  endfunction

  function automatic bit framing_fault(output frame_beat_t r, input logic [ERR_W-1:0] code);
    phase_q    = PH_RESYNC;
    args_left  = '0;
    arg_idx    = '0;
    bytes_left = '0;
    clear_number();
    r = '0;
    r.error_code = code;
    return 1'b1;
  endfunction

  // One byte through the mirror; 1 when it yields a beat
  function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output frame_beat_t r);
    logic [31:0] count_limit;
    logic        closing;
    r = '0;
    count_limit = (arg_limit_reg < MAX_ARGS_DEF) ? 32'(arg_limit_reg) : 32'(MAX_ARGS_DEF);
    case (phase_q)
      PH_HEADER, PH_RESYNC: begin
        if (b == CH_STAR) begin
          clear_number();
          phase_q = PH_COUNT;
          return 1'b0;
        end
        if (phase_q == PH_HEADER)
          return framing_fault(r, ERR_LEAD);
        return 1'b0;
      end
      PH_COUNT: begin
        if (b == CH_LF) begin
          if (num_val == '0) begin
            phase_q = PH_HEADER;
          end else begin
            args_left = num_val[CNT_W-1:0];
            arg_idx   = '0;
            phase_q   = PH_LEAD;
          end
          clear_number();
          return 1'b0;
        end
        if (number_breaks(b, count_limit))
          return framing_fault(r, ERR_COUNT);
        return 1'b0;
      end
      PH_LEAD: begin
        if (b == CH_DOLLAR) begin
          clear_number();
          phase_q = PH_LENGTH;
          return 1'b0;
        end
        return framing_fault(r, ERR_LEAD);
      end
      PH_LENGTH: begin
        if (b == CH_LF) begin
          if (num_val == '0) begin
            bytes_left = TRAIL_LEN;
            phase_q    = PH_TRAIL;
          end else begin
            bytes_left = num_val;
            phase_q    = PH_DATA;
          end
          clear_number();
          return 1'b0;
        end
        if (number_breaks(b, 32'(len_limit_reg)))
          return framing_fault(r, ERR_LEN);
        return 1'b0;
      end
      PH_DATA: begin
        r.data_byte     = b;
        r.payload_valid = 1'b1;
        r.arg_number    = arg_idx;
        bytes_left      = bytes_left - 1'b1;
        if (bytes_left == '0) begin
          bytes_left = TRAIL_LEN;
          phase_q    = PH_TRAIL;
        end
        return 1'b1;
      end
      PH_TRAIL: begin
        bytes_left = bytes_left - 1'b1;
        if (bytes_left != '0)
          return 1'b0;
        closing       = (args_left <= 1);
        r.arg_number  = arg_idx;
        r.arg_end     = 1'b1;
        r.command_end = closing;
        if (closing) begin
          args_left = '0;
          arg_idx   = '0;
          phase_q   = PH_HEADER;
        end else begin
          args_left = args_left - 1'b1;
          arg_idx   = arg_idx + 1'b1;
          phase_q   = PH_LEAD;
        end
        return 1'b1;
      end
      default: begin
        phase_q = PH_RESYNC;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input frame_beat_t want,
                                 input frame_beat_t seen);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("%0t %s: expected byte=%h pv=%b arg=%0d aend=%b cend=%b err=%0d, got byte=%h pv=%b arg=%0d aend=%b cend=%b err=%0d",
               $time, what, want.data_byte, want.payload_valid, want.arg_number, want.arg_end,
               want.command_end, want.error_code, seen.data_byte, seen.payload_valid,
               seen.arg_number, seen.arg_end, seen.command_end, seen.error_code);
  endtask

  // Input beat: random gaps, then hold until taken; returns at a falling edge
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic feed_byte(input logic [BYTE_W-1:0] b, input bit typed,
                           input logic [ERR_W-1:0] typed_err);
    frame_beat_t r;
    frame_beat_t want;
    bit          got;
    got = deframe_byte(b, r);
    if (typed) begin
      want = '0;
      want.error_code = typed_err;
      if (!got || r !== want)
        report_mismatch("directed row disagrees with mirror", want, r);
      r   = want;
      got = 1'b1;
    end
    if (got)
      expected_beats.push_back(r);
    send_byte(b);
    bytes_fed++;
  endtask

  // Idle the input, let every expected beat arrive, then the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(input logic idx, input logic [LEN_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_MAX_ARG_COUNT)
      arg_limit_reg = value[CNT_W-1:0];
    else
      len_limit_reg = value;
    @(negedge clk);
  endtask

  function automatic void push_digits(input int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++)
      pending_bytes.push_back(8'(s[i]));
  endfunction

  // Decimal number with occasional leading zeros, CR and a frozen tail
  function automatic void push_number(input int unsigned v);
    if ($urandom_range(9) == 0)
      repeat ($urandom_range(1, 3)) pending_bytes.push_back(CH_ZERO);
    push_digits(v);
    if ($urandom_range(9) == 0)
      pending_bytes.push_back(CH_CR);
    if ($urandom_range(9) == 0) begin
      pending_bytes.push_back(8'($urandom_range(97, 122)));  // lower-case letter
      pending_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
    end
    pending_bytes.push_back(CH_LF);
  endfunction

  function automatic void push_argument(input int unsigned len);
    pending_bytes.push_back(CH_DOLLAR);
    push_number(len);
    repeat (len) pending_bytes.push_back(8'($urandom_range(255)));
    repeat (2) pending_bytes.push_back(8'($urandom_range(255)));
  endfunction

  // Mostly well-formed commands, the rest broken framing and noise
  function automatic void build_command();
    int unsigned count_cap;
    int unsigned len_cap;
    int unsigned n;
    int unsigned len;
    int unsigned sel;
    logic [BYTE_W-1:0] bad;
    count_cap = (arg_limit_reg < MAX_ARGS_DEF) ? arg_limit_reg : MAX_ARGS_DEF;
    len_cap   = (len_limit_reg < 12) ? len_limit_reg : 12;
    sel = $urandom_range(99);
    if (sel < 80) begin
      if (count_cap <= 7 && $urandom_range(3) == 0)
        n = count_cap;
      else
        n = $urandom_range(1, (count_cap < 4) ? count_cap : 4);
      pending_bytes.push_back(CH_STAR);
      push_number(n);
      repeat (n) begin
        if (len_limit_reg <= 40 && $urandom_range(9) == 0)
          len = len_limit_reg;
        else
          len = $urandom_range(0, len_cap);
        push_argument(len);
      end
    end else if (sel < 84) begin
      pending_bytes.push_back(CH_STAR);
      push_number(0);
    end else if (sel < 89) begin
      // count just over its limit
      pending_bytes.push_back(CH_STAR);
      push_digits(count_cap + 1 + $urandom_range(0, 50));
      pending_bytes.push_back(CH_LF);
    end else if (sel < 93) begin
      // length just over its limit
      pending_bytes.push_back(CH_STAR);
      push_number(1);
      pending_bytes.push_back(CH_DOLLAR);
      push_digits(len_limit_reg + 1 + $urandom_range(0, 50));
      pending_bytes.push_back(CH_LF);
    end else if (sel < 95) begin
      // one digit too many, carried by leading zeros
      pending_bytes.push_back(CH_STAR);
      if ($urandom_range(1)) begin
        push_number(1);
        pending_bytes.push_back(CH_DOLLAR);
      end
      repeat (MAX_DIGITS_DEF) pending_bytes.push_back(CH_ZERO);
      pending_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
      pending_bytes.push_back(CH_LF);
    end else if (sel < 97) begin
      // wrong lead byte where an argument should start
      pending_bytes.push_back(CH_STAR);
      push_number((count_cap < 2) ? 1 : 2);
      bad = 8'($urandom_range(255));
      if (bad == CH_DOLLAR)
        bad = CH_STAR;
      pending_bytes.push_back(bad);
    end else begin
      repeat ($urandom_range(1, 6)) pending_bytes.push_back(8'($urandom_range(255)));
    end
  endfunction

  // Receiver back-pressure
  always @(negedge clk)
    out_stall <= ($urandom_range(99) < recv_idle_pct);

  // Output check and watchdog
  always @(posedge clk) begin : out_check
    frame_beat_t seen;
    frame_beat_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        seen = {data_byte, payload_valid, arg_number, arg_end, command_end, error_code};
        if (seen.error_code != ERR_NONE)
          error_beats++;
        if (seen.command_end)
          commands_closed++;
        if (expected_beats.size() == 0) begin
          report_mismatch("unexpected beat", '0, seen);
        end else begin
          want = expected_beats.pop_front();
          beats_checked++;
          if (seen !== want)
            report_mismatch("beat mismatch", want, seen);
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    send_idle_pct = limit_plans[0].send_pct;
    recv_idle_pct = limit_plans[0].recv_pct;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed rows at reset limits
    foreach (directed_rows[r]) begin
      for (int i = 0; i < directed_rows[r].text.len(); i++)
        feed_byte(8'(directed_rows[r].text[i]),
                  directed_rows[r].typed && (i == directed_rows[r].text.len() - 1),
                  directed_rows[r].err);
    end
    settle();

    // random commands under each limit setting
    foreach (limit_plans[p]) begin
      write_reg(REG_MAX_ARG_COUNT, LEN_W'(limit_plans[p].arg_cap));
      write_reg(REG_MAX_BULK_LENGTH, LEN_W'(limit_plans[p].len_cap));
      cfg_valid <= 1'b0;
      send_idle_pct = limit_plans[p].send_pct;
      recv_idle_pct = limit_plans[p].recv_pct;
      begin : phase_body
        int unsigned target;
        target = bytes_fed + PHASE_BYTES;
        while (bytes_fed < target) begin
          build_command();
          while (pending_bytes.size() != 0)
            feed_byte(pending_bytes.pop_front(), 1'b0, ERR_NONE);
        end
      end
      settle();
    end

    if (expected_beats.size() != 0) begin
      $display("%0d expected beats never arrived", expected_beats.size());
      mismatches++;
    end
    $display("Fed %0d stream bytes over %0d limit settings, %0d beats checked",
             bytes_fed, NUM_PHASES + 1, beats_checked);
    $display("Beats carried %0d framing errors and closed %0d commands; %0d mismatches",
             error_beats, commands_closed, mismatches);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mrp_pkg.sv
rtl/multibulk_request_parser.sv
rtl/multibulk_request_parser_checker.sv
bench/tb_multibulk_request_parser.sv
